>>> rtl/pslt_pkg.sv
// Shared constants and register codes of the packet sequence loss tracker.
`timescale 1ns / 1ps
package pslt_pkg;

  localparam int unsigned SEQ_W  = 64;
  localparam int unsigned LEN_W  = 17;
  localparam int unsigned INCR_W = 16;
  localparam int unsigned HALF_W = SEQ_W / 2;

  localparam logic [SEQ_W-1:0] NONE_SEEN = {SEQ_W{1'b1}};

  localparam logic REG_WAIT_PPS = 1'b0;
  localparam logic REG_INCR     = 1'b1;

endpackage

>>> rtl/pslt_divider.sv
// Iterative restoring divider of a 64-bit dividend by a 16-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module pslt_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pslt_pkg::SEQ_W-1:0]      dividend_i,
  input  logic [pslt_pkg::INCR_W-1:0]     divisor_i,
  output logic                            done_o,
  output logic [pslt_pkg::SEQ_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(pslt_pkg::SEQ_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pslt_pkg::SEQ_W - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [pslt_pkg::SEQ_W-1:0]    quot_q, quot_d;
  logic [pslt_pkg::INCR_W-1:0]   rem_q, rem_d;
  logic [pslt_pkg::INCR_W-1:0]   div_q, div_d;
  logic [pslt_pkg::INCR_W:0]     rem_shift;
  logic [pslt_pkg::INCR_W:0]     rem_sub;
  logic                          fits;

  assign rem_shift = {rem_q, quot_q[pslt_pkg::SEQ_W-1]};
  assign fits      = rem_shift >= {1'b0, div_q};
  assign rem_sub   = rem_shift - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[pslt_pkg::SEQ_W-2:0], fits};
      rem_d  = fits ? rem_sub[pslt_pkg::INCR_W-1:0] : rem_shift[pslt_pkg::INCR_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

>>> rtl/pslt_multiplier.sv
// Multiplier of a 64-bit count by a 17-bit length modulo 2^64, on one shared 32x17 unit.
`timescale 1ns / 1ps
module pslt_multiplier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pslt_pkg::SEQ_W-1:0]    count_i,
  input  logic [pslt_pkg::LEN_W-1:0]    length_i,
  output logic                          done_o,
  output logic [pslt_pkg::SEQ_W-1:0]    product_o
);

  localparam int unsigned HW = pslt_pkg::HALF_W;
  localparam int unsigned PW = HW + pslt_pkg::LEN_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]                     phase_q, phase_d;
  logic                           done_q, done_d;
  logic [pslt_pkg::SEQ_W-1:0]     cnt_q;
  logic [pslt_pkg::LEN_W-1:0]     len_q;
  logic [PW-1:0]                  lo_q;
  logic [HW-1:0]                  hi_q;
  logic [pslt_pkg::SEQ_W-1:0]     prod_q;
  logic [HW-1:0]                  op_a;
  logic [PW-1:0]                  partial;

  assign op_a    = (phase_q == PH_HI) ? cnt_q[pslt_pkg::SEQ_W-1:HW] : cnt_q[HW-1:0];
  assign partial = {{pslt_pkg::LEN_W{1'b0}}, op_a} * {{HW{1'b0}}, len_q};

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_LO;
        end
      end
      PH_LO:  phase_d = PH_HI;
      PH_HI:  phase_d = PH_SUM;
      PH_SUM: begin
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (phase_q == PH_IDLE)) begin
      cnt_q <= count_i;
      len_q <= length_i;
    end
    if (phase_q == PH_LO) begin
      lo_q <= partial;
    end
    if (phase_q == PH_HI) begin
      hi_q <= partial[HW-1:0];
    end
    if (phase_q == PH_SUM) begin
      prod_q <= {{(pslt_pkg::SEQ_W-PW){1'b0}}, lo_q} + {hi_q, {HW{1'b0}}};
    end
  end

  assign done_o    = done_q;
  assign product_o = prod_q;

endmodule

>>> rtl/packet_sequence_loss_tracker.sv
// Top level of the packet sequence loss tracker with its sequencer and register port.
`timescale 1ns / 1ps
// Each request is one received packet, given by its 64-bit sequence counter and its byte
// length, and it yields exactly one result. The block takes one packet at a time and holds
// in_stall_o high while it works. A packet of length zero goes straight to its result, and
// after a gap the gap size comes from a divider that produces one quotient bit per cycle;
// while recording, the filler byte count is then formed on a shared 32x17 multiplier. A
// finished result waits in an output register, and the next packet may be taken meanwhile.
// The user must write configuration through the register port only while the block is
// idle; the block itself does not enforce this.
module packet_sequence_loss_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pslt_pkg::SEQ_W-1:0]    sequence_count_i,
  input  logic [pslt_pkg::LEN_W-1:0]    packet_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          stored_o,
  output logic                          pps_start_o,
  output logic                          gap_seen_o,
  output logic [pslt_pkg::SEQ_W-1:0]    missing_count_o,
  output logic [pslt_pkg::SEQ_W-1:0]    fill_count_o,
  output logic [pslt_pkg::SEQ_W-1:0]    lost_running_total_o,
  output logic [pslt_pkg::SEQ_W-1:0]    byte_running_total_o
);

  localparam int unsigned SW = pslt_pkg::SEQ_W;
  localparam int unsigned IW = pslt_pkg::INCR_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_NUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_BYTE = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]                     state_q, state_d;
  logic                           wait_pps_q;
  logic [IW-1:0]                  incr_cfg_q;
  logic                           rec_q;
  logic [SW-1:0]                  prev_q;
  logic [SW-1:0]                  lost_q;
  logic [SW-1:0]                  byte_q;
  logic [SW-1:0]                  curr_q;
  logic [pslt_pkg::LEN_W-1:0]     len_q;
  logic [IW-1:0]                  incr_q;
  logic [SW-1:0]                  diff_q;
  logic [SW-1:0]                  missing_q;
  logic                           pps_q;
  logic                           gap_q;
  logic                           out_valid_q;
  logic                           stored_q;
  logic                           pps_out_q;
  logic                           gap_out_q;
  logic [SW-1:0]                  missing_out_q;
  logic [SW-1:0]                  fill_out_q;
  logic [SW-1:0]                  lost_out_q;
  logic [SW-1:0]                  byte_out_q;

  logic                           cfg_write;
  logic                           in_accept;
  logic                           out_load;
  logic                           none_seen;
  logic                           behind;
  logic                           on_step;
  logic                           div_start;
  logic                           div_done;
  logic [SW-1:0]                  quotient;
  logic [SW-1:0]                  missing_calc;
  logic                           mul_start;
  logic                           mul_done;
  logic [SW-1:0]                  product;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign none_seen    = (prev_q == pslt_pkg::NONE_SEEN);
  assign behind       = curr_q < prev_q;
  assign on_step      = (prev_q + {{(SW-IW){1'b0}}, incr_q}) == curr_q;
  assign div_start    = (state_q == ST_NUM);
  assign missing_calc = quotient - SW'(1);
  assign mul_start    = (state_q == ST_DIV) && div_done && rec_q;

  always_comb begin
    case (paddr[2])
      pslt_pkg::REG_WAIT_PPS: prdata = {31'd0, wait_pps_q};
      pslt_pkg::REG_INCR:     prdata = {{(32-IW){1'b0}}, incr_cfg_q};
      default:                prdata = '0;
    endcase
  end

  pslt_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_q + {{(SW-IW){1'b0}}, incr_q - IW'(1)}),
    .divisor_i  (incr_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  pslt_multiplier u_multiplier (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .count_i   (missing_calc),
    .length_i  (len_q),
    .done_o    (mul_done),
    .product_o (product)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (len_q == '0) begin
          state_d = ST_FIN;
        end else if (!none_seen && !rec_q && behind) begin
          state_d = ST_BYTE;
        end else if (!none_seen && !on_step) begin
          state_d = ST_NUM;
        end else begin
          state_d = ST_BYTE;
        end
      end
      ST_NUM: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = rec_q ? ST_MUL : ST_ACC;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC:  state_d = ST_BYTE;
      ST_BYTE: state_d = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_pps_q  <= 1'b0;
      incr_cfg_q  <= IW'(1);
      rec_q       <= 1'b1;
      prev_q      <= pslt_pkg::NONE_SEEN;
      lost_q      <= '0;
      byte_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_write && (paddr[2] == pslt_pkg::REG_WAIT_PPS)) begin
        wait_pps_q <= pwdata[0];
        rec_q      <= !pwdata[0];
      end else if ((state_q == ST_CHK) && (len_q != '0) && !none_seen && !rec_q && behind) begin
        rec_q <= 1'b1;
      end
      if (cfg_write && (paddr[2] == pslt_pkg::REG_INCR)) begin
        incr_cfg_q <= pwdata[IW-1:0];
      end
      if (state_q == ST_ACC) begin
        lost_q <= lost_q + missing_q;
        if (rec_q) begin
          byte_q <= byte_q + product;
        end
      end
      if (state_q == ST_BYTE) begin
        prev_q <= curr_q;
        if (rec_q) begin
          byte_q <= byte_q + {{(SW-pslt_pkg::LEN_W){1'b0}}, len_q};
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      curr_q <= sequence_count_i;
      len_q  <= packet_length_i;
      incr_q <= (incr_cfg_q == '0) ? IW'(1) : incr_cfg_q;
    end
    if (state_q == ST_CHK) begin
      diff_q    <= curr_q - prev_q;
      missing_q <= '0;
      pps_q     <= (len_q != '0) && !none_seen && !rec_q && behind;
      gap_q     <= (len_q != '0) && !none_seen && !(!rec_q && behind) && !on_step;
    end
    if ((state_q == ST_DIV) && div_done) begin
      missing_q <= missing_calc;
    end
    if (out_load) begin
      stored_q      <= rec_q && (len_q != '0);
      pps_out_q     <= pps_q;
      gap_out_q     <= gap_q;
      missing_out_q <= missing_q;
      fill_out_q    <= rec_q ? missing_q : '0;
      lost_out_q    <= lost_q;
      byte_out_q    <= byte_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign stored_o             = stored_q;
  assign pps_start_o          = pps_out_q;
  assign gap_seen_o           = gap_out_q;
  assign missing_count_o      = missing_out_q;
  assign fill_count_o         = fill_out_q;
  assign lost_running_total_o = lost_out_q;
  assign byte_running_total_o = byte_out_q;

endmodule
